// ----- sv/rsc_pkg.sv -----
// Package for the relay switch context controller.
// Holds the item types, context and register codes shared by the module files.
// No dependencies.
package rsc_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int NOW_W       = 32;
  localparam int INTERVAL_MS_W = 26;
  localparam int MS_PER_S    = 1000;

  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_MODE       = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME         = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTION_ON_TIME    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_EXPIRE_OFF   = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELAY_ACTIVE_HIGH = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LED_ACTIVE_HIGH   = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_ENABLE     = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTION_PRESENT    = 4'd7;

  localparam logic [1:0] OP_POLL = 2'd0;
  localparam logic [1:0] OP_NET  = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;

  localparam logic [1:0] BTN_ON_ONLY  = 2'd1;
  localparam logic [1:0] BTN_OFF_ONLY = 2'd2;

  typedef enum logic [1:0] {
    CTX_INIT    = 2'd0,
    CTX_MANUAL  = 2'd1,
    CTX_NETWORK = 2'd2,
    CTX_MOTION  = 2'd3
  } ctx_t;

  typedef enum logic [1:0] {
    KIND_POLL,
    KIND_NET,
    KIND_INIT,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              want;
    logic              press;
    logic              motion;
    logic [NOW_W-1:0]  now_ms;
  } item_t;

endpackage

// ----- sv/rsc_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on nothing; widths follow the field list of the block.
interface rsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        new_state;
  logic        button_pressed;
  logic        motion_sensed;
  logic [31:0] now_ms;
  modport source (output valid, opcode, new_state, button_pressed, motion_sensed, now_ms,
                  input ready);
  modport sink (input valid, opcode, new_state, button_pressed, motion_sensed, now_ms,
                output ready);
endinterface

interface rsc_out_if;
  logic       valid;
  logic       ready;
  logic       switch_on;
  logic       relay_level;
  logic       led_level;
  logic [1:0] context_res;
  logic       applied;
  modport source (output valid, switch_on, relay_level, led_level, context_res, applied,
                  input ready);
  modport sink (input valid, switch_on, relay_level, led_level, context_res, applied,
                output ready);
endinterface

// ----- sv/rsc_front.sv -----
// Front end: accepts requests and classifies them by opcode.
// Depends on rsc_pkg and rsc_in_if.
module rsc_front (
  input  logic         rst,
  rsc_in_if.sink       in_ch,
  input  logic         q_ready,
  output logic         q_push,
  output rsc_pkg::item_t q_item
);
  import rsc_pkg::*;

  kind_t kind;

  always_comb begin
    unique case (in_ch.opcode)
      OP_POLL: kind = KIND_POLL;
      OP_NET:  kind = KIND_NET;
      OP_INIT: kind = KIND_INIT;
      default: kind = KIND_NOP;
    endcase
  end

  assign in_ch.ready = q_ready && !rst;
  assign q_push      = in_ch.valid && in_ch.ready;
  assign q_item      = '{kind:   kind,
                         want:   in_ch.new_state,
                         press:  in_ch.button_pressed,
                         motion: in_ch.motion_sensed,
                         now_ms: in_ch.now_ms};
endmodule

// ----- sv/rsc_queue.sv -----
// Two-entry request queue between the front and back ends.
// Depends on rsc_pkg.
module rsc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsc_pkg::item_t push_item,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output rsc_pkg::item_t pop_item
);
  import rsc_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> (count == 2'd2))
    else $error("queue lost or gained an entry while full");
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("pop from an empty queue");
endmodule

// ----- sv/rsc_back.sv -----
// Back end: switch state, configuration registers and the result register.
// Depends on rsc_pkg and rsc_out_if.
module rsc_back #(
  parameter int GUARD_MS       = 2000,
  parameter int MIN_INTERVAL_S = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             q_valid,
  input  rsc_pkg::item_t                   q_item,
  output logic                             q_pop,
  rsc_out_if.source                        out_ch
);
  import rsc_pkg::*;

  logic [1:0]               button_mode;
  logic [INTERVAL_MS_W-1:0] manual_ms;
  logic [INTERVAL_MS_W-1:0] motion_ms;
  logic                     hold_expire_off;
  logic                     relay_active_high;
  logic                     led_active_high;
  logic                     manual_enable;
  logic                     motion_present;

  logic                     is_on;
  ctx_t                     ctx;
  logic [NOW_W-1:0]         last_ms;

  logic                     is_on_next;
  ctx_t                     ctx_next;
  logic                     applied_next;

  logic [CFG_DATA_W-1:0]    clamped;
  logic [INTERVAL_MS_W-1:0] clamped_ms;
  logic [NOW_W-1:0]         elapsed;
  logic                     poll_run;
  logic                     man_act;
  logic                     mot_act;
  logic                     on1;
  ctx_t                     ctx1;
  logic                     set1;

  always_comb begin
    clamped = cfg_data;
    if (cfg_data != '0 && cfg_data < CFG_DATA_W'(MIN_INTERVAL_S)) begin
      clamped = CFG_DATA_W'(MIN_INTERVAL_S);
    end
    clamped_ms = INTERVAL_MS_W'(clamped) * INTERVAL_MS_W'(MS_PER_S);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_mode       <= '0;
      manual_ms         <= '0;
      motion_ms         <= '0;
      hold_expire_off   <= 1'b0;
      relay_active_high <= 1'b1;
      led_active_high   <= 1'b1;
      manual_enable     <= 1'b0;
      motion_present    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUTTON_MODE:       button_mode       <= cfg_data[1:0];
        REG_HOLD_TIME:         manual_ms         <= clamped_ms;
        REG_MOTION_ON_TIME:    motion_ms         <= clamped_ms;
        REG_HOLD_EXPIRE_OFF:   hold_expire_off   <= cfg_data[0];
        REG_RELAY_ACTIVE_HIGH: relay_active_high <= cfg_data[0];
        REG_LED_ACTIVE_HIGH:   led_active_high   <= cfg_data[0];
        REG_MANUAL_ENABLE:     manual_enable     <= cfg_data[0];
        REG_MOTION_PRESENT:    motion_present    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign elapsed  = q_item.now_ms - last_ms;
  assign man_act  = (manual_ms != '0);
  assign mot_act  = (motion_ms != '0);
  assign poll_run = (q_item.kind == KIND_POLL) && (elapsed >= NOW_W'(GUARD_MS));

  // The motion step sees the state left by the button step.
  always_comb begin
    on1  = is_on;
    ctx1 = ctx;
    set1 = 1'b0;
    if (poll_run && manual_enable) begin
      if (q_item.press) begin
        case (button_mode)
          BTN_ON_ONLY: begin
            if (!is_on) begin
              on1  = 1'b1;
              ctx1 = CTX_MANUAL;
              set1 = 1'b1;
            end
          end
          BTN_OFF_ONLY: begin
            if (is_on) begin
              on1  = 1'b0;
              ctx1 = CTX_MANUAL;
              set1 = 1'b1;
            end
          end
          default: begin
            on1  = !is_on;
            ctx1 = CTX_MANUAL;
            set1 = 1'b1;
          end
        endcase
      end else if (ctx == CTX_MANUAL && man_act &&
                   elapsed >= NOW_W'(manual_ms)) begin
        on1  = hold_expire_off ? 1'b0 : is_on;
        ctx1 = CTX_INIT;
        set1 = 1'b1;
      end
    end
  end

  always_comb begin
    is_on_next   = on1;
    ctx_next     = ctx1;
    applied_next = set1;
    case (q_item.kind)
      KIND_NET: begin
        if (!((ctx == CTX_MANUAL && man_act) || (ctx == CTX_MOTION && mot_act))) begin
          is_on_next   = q_item.want;
          ctx_next     = CTX_NETWORK;
          applied_next = 1'b1;
        end
      end
      KIND_INIT: begin
        is_on_next   = q_item.want;
        ctx_next     = CTX_INIT;
        applied_next = 1'b1;
      end
      KIND_POLL: begin
        if (poll_run && motion_present && mot_act) begin
          if (q_item.motion) begin
            if (!(ctx1 == CTX_MANUAL && man_act)) begin
              is_on_next   = 1'b1;
              ctx_next     = CTX_MOTION;
              applied_next = 1'b1;
            end
          end else if (on1 && ctx1 == CTX_MOTION &&
                       elapsed >= NOW_W'(motion_ms)) begin
            is_on_next   = 1'b0;
            ctx_next     = CTX_INIT;
            applied_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign q_pop = q_valid && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      is_on        <= 1'b0;
      ctx          <= CTX_INIT;
      last_ms      <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        is_on <= is_on_next;
        ctx   <= ctx_next;
        if (applied_next) last_ms <= q_item.now_ms;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_ch.switch_on   <= is_on_next;
      out_ch.relay_level <= relay_active_high ? is_on_next : !is_on_next;
      out_ch.led_level   <= led_active_high ? is_on_next : !is_on_next;
      out_ch.context_res <= ctx_next;
      out_ch.applied     <= applied_next;
    end
  end

  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_ch.valid)
    else $error("request taken without a result");
  a_nop_not_applied: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.kind == KIND_NOP) |=> !out_ch.applied)
    else $error("unused opcode reported a set");
  a_applied_stamps: assert property (@(posedge clk) disable iff (rst)
    (q_pop && applied_next) |=> (last_ms == $past(q_item.now_ms)))
    else $error("applied set did not record its time");
  a_idle_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !applied_next) |=> ($stable(is_on) && $stable(ctx) && $stable(last_ms)))
    else $error("state changed without an applied set");
endmodule

// ----- sv/relay_switch_context_controller.sv -----
// Relay switch context controller: one relay with on/off state, context and
// last-activity time. Request channel in_ch carries polls and set requests;
// result channel out_ch returns one result per request, in order.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data. Indexes
// 0..7 select the button mode, the manual hold time, the motion on-time, the
// switch-off on hold expiry, relay polarity, LED polarity, manual enable and
// motion sensor present; higher indexes are ignored. Write only while no
// request is pending.
// A request accepted on in_ch is held in a two-entry queue; the back end takes
// it from the queue head and its result is registered on out_ch. Throughput
// is one request per cycle while out_ch does not stall; the back end updates
// the state of one request per cycle from the queue head.
// When out_ch stalls the result register holds and the queue fills both its
// entries before in_ch.ready drops.
// Synchronous reset clears the state to off in init context, time 0, and
// restores register defaults (both polarities active high). Ready is low
// while reset is asserted.
// Depends on rsc_pkg, rsc_if, rsc_front, rsc_queue and rsc_back.
module relay_switch_context_controller #(
  parameter int GUARD_MS       = 2000,
  parameter int MIN_INTERVAL_S = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  rsc_in_if.sink                          in_ch,
  rsc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rsc_pkg::*;

  logic  push;
  logic  push_ready;
  item_t push_item;
  logic  pop;
  logic  pop_valid;
  item_t pop_item;

  rsc_front u_front (
    .rst     (rst),
    .in_ch   (in_ch),
    .q_ready (push_ready),
    .q_push  (push),
    .q_item  (push_item)
  );

  rsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  rsc_back #(
    .GUARD_MS       (GUARD_MS),
    .MIN_INTERVAL_S (MIN_INTERVAL_S)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (pop_valid),
    .q_item    (pop_item),
    .q_pop     (pop),
    .out_ch    (out_ch)
  );
endmodule
